// ===== hw/rtl/ill_pkg.sv =====
// Package for the indexed linked list engine: request and response types,
// the token that runs down the cell chain, and the shared sizing constants.
// No dependencies.
package ill_pkg;

  // Sizing of the list. The cell index, the position and the count are
  // the fixed widths of the request and response fields.
  localparam int CAPACITY = 128;
  localparam int IDX_W    = 7;
  localparam int CNT_W    = 8;
  localparam int DATA_W   = 32;

  // Commands as they arrive in a request.
  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_SEARCH = 3'd5
  } ill_cmd_t;

  // Response status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } ill_status_t;

  // What each cell does when the token passes it.
  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_SET    = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SEARCH = 3'd4
  } ill_op_t;

  // Controller state.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_BUSY = 2'd1,
    S_DONE = 2'd2
  } ill_state_t;

  // One request on the input channel.
  typedef struct packed {
    logic [2:0]               command;
    logic [IDX_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } ill_in_t;

  // One result on the output channel.
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data_out;
    logic                     found;
    logic [IDX_W-1:0]         found_position;
    logic [CNT_W-1:0]         list_length;
  } ill_out_t;

  // Token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic              valid;
    ill_op_t           op;
    logic [IDX_W-1:0]  idx;       // index of the cell that sees the token
    logic [IDX_W-1:0]  pos;       // target list position
    logic [CNT_W-1:0]  count;     // list length before the command
    logic [DATA_W-1:0] key;       // value to write or to look for
    logic [DATA_W-1:0] carry;     // value being read out or shifted along
    logic              found;
    logic [IDX_W-1:0]  found_pos;
  } ill_tok_t;

endpackage

// ===== hw/rtl/ill_cell.sv =====
// One cell of the list chain: holds the entry at its list position and
// applies the passing token to it. Depends on ill_pkg.
module ill_cell
  import ill_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ill_tok_t          tok_in,
  output ill_tok_t          tok_out,
  input  logic [DATA_W-1:0] nbr_in,     // entry of the next cell
  output logic [DATA_W-1:0] value_out
);

  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;
  ill_tok_t          tok_r;
  ill_tok_t          tok_nxt;
  logic              at_pos;
  logic              past_pos;
  logic              in_list;

  // Where this cell stands relative to the target and the list end.
  assign at_pos   = tok_in.valid && (tok_in.idx == tok_in.pos);
  assign past_pos = tok_in.valid && (tok_in.idx >= tok_in.pos);
  assign in_list  = tok_in.valid && ({1'b0, tok_in.idx} < tok_in.count);

  // Cell update and token forwarding.
  always_comb begin
    value_nxt   = value_r;
    tok_nxt     = tok_in;
    tok_nxt.idx = tok_in.idx + IDX_W'(1);
    case (tok_in.op)
      OP_READ: begin
        if (at_pos) tok_nxt.carry = value_r;
      end
      OP_SET: begin
        if (at_pos) begin
          tok_nxt.carry = value_r;
          value_nxt     = tok_in.key;
        end
      end
      OP_INSERT: begin
        // Every cell from the target on takes the carried entry and passes
        // its own entry one cell further.
        if (past_pos) begin
          value_nxt     = tok_in.carry;
          tok_nxt.carry = value_r;
        end
      end
      OP_REMOVE: begin
        // The next cell has not been touched yet, so its entry moves down.
        if (at_pos) tok_nxt.carry = value_r;
        if (past_pos) value_nxt = nbr_in;
      end
      OP_SEARCH: begin
        if (in_list && !tok_in.found && (value_r == tok_in.key)) begin
          tok_nxt.found     = 1'b1;
          tok_nxt.found_pos = tok_in.idx;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry storage; its contents beyond the list length mean nothing.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  // Token register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out   = tok_r;
  assign value_out = value_r;

endmodule

// ===== hw/rtl/ill_chain.sv =====
// Row of list cells; cell i holds list position i and the token walks the
// row one cell per cycle. Depends on ill_pkg and ill_cell.
module ill_chain
  import ill_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ill_tok_t tok_in,
  output ill_tok_t tok_out
);

  ill_tok_t          tok_w [CAPACITY];
  logic [DATA_W-1:0] val_w [CAPACITY];

  // Cells are wired to their neighbors only.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ill_tok_t          tok_src;
    logic [DATA_W-1:0] nbr_src;

    if (i == 0) begin : g_first
      assign tok_src = tok_in;
    end else begin : g_next
      assign tok_src = tok_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign nbr_src = '0;
    end else begin : g_mid
      assign nbr_src = val_w[i+1];
    end

    ill_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_in    (tok_src),
      .tok_out   (tok_w[i]),
      .nbr_in    (nbr_src),
      .value_out (val_w[i])
    );
  end

  assign tok_out = tok_w[CAPACITY-1];

endmodule

// ===== hw/rtl/ill_ctrl.sv =====
// Controller of the list engine: checks each request against the length,
// launches the token into the cell chain and holds the response.
// Depends on ill_pkg.
module ill_ctrl
  import ill_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ill_in_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output ill_out_t out_rsp,
  output ill_tok_t launch,
  input  ill_tok_t chain_tok
);

  ill_state_t       state_r;
  ill_state_t       state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  ill_cmd_t         cmd_r;
  ill_cmd_t         cmd_nxt;
  ill_out_t         rsp_r;
  ill_out_t         rsp_nxt;
  ill_tok_t         launch_r;
  ill_tok_t         launch_nxt;
  logic             take;
  logic             pos_bad;
  logic             full;
  logic             direct;
  ill_status_t      direct_stat;

  // A new request is taken when idle or as the waiting response leaves.
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_DONE) && !out_stall));
  assign take     = in_valid && !in_stall;
  assign pos_bad  = ({1'b0, in_req.position} >= count_r);
  assign full     = (count_r == CNT_W'(CAPACITY));

  // Next state, token launch and response.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cmd_nxt     = cmd_r;
    rsp_nxt     = rsp_r;
    launch_nxt  = '0;
    direct      = 1'b0;
    direct_stat = STAT_OK;

    case (state_r)
      S_IDLE: begin
      end
      S_BUSY: begin
        // Token is back from the last cell: build the response.
        if (chain_tok.valid) begin
          rsp_nxt.status         = STAT_OK;
          rsp_nxt.data_out       = '0;
          rsp_nxt.found          = chain_tok.found;
          rsp_nxt.found_position = chain_tok.found_pos;
          case (cmd_r)
            CMD_GET, CMD_SET: begin
              rsp_nxt.data_out = chain_tok.carry;
            end
            CMD_REMOVE: begin
              rsp_nxt.data_out = chain_tok.carry;
              count_nxt        = count_r - CNT_W'(1);
            end
            CMD_APPEND, CMD_INSERT: begin
              count_nxt = count_r + CNT_W'(1);
            end
            default: begin
            end
          endcase
          rsp_nxt.list_length = count_nxt;
          state_nxt           = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Start of a new request.
    if (take) begin
      cmd_nxt          = ill_cmd_t'(in_req.command);
      launch_nxt.pos   = in_req.position;
      launch_nxt.count = count_r;
      launch_nxt.key   = in_req.value;
      case (ill_cmd_t'(in_req.command))
        CMD_GET: begin
          launch_nxt.op = OP_READ;
          if (pos_bad) begin
            direct      = 1'b1;
            direct_stat = STAT_RANGE;
          end
        end
        CMD_SET: begin
          launch_nxt.op = OP_SET;
          if (pos_bad) begin
            direct      = 1'b1;
            direct_stat = STAT_RANGE;
          end
        end
        CMD_REMOVE: begin
          launch_nxt.op = OP_REMOVE;
          if (pos_bad) begin
            direct      = 1'b1;
            direct_stat = STAT_RANGE;
          end
        end
        CMD_INSERT: begin
          launch_nxt.op    = OP_INSERT;
          launch_nxt.carry = in_req.value;
          if (pos_bad) begin
            direct      = 1'b1;
            direct_stat = STAT_RANGE;
          end else if (full) begin
            direct      = 1'b1;
            direct_stat = STAT_FULL;
          end
        end
        CMD_APPEND: begin
          // An append is an insert at the list end.
          launch_nxt.op    = OP_INSERT;
          launch_nxt.pos   = count_r[IDX_W-1:0];
          launch_nxt.carry = in_req.value;
          if (full) begin
            direct      = 1'b1;
            direct_stat = STAT_FULL;
          end
        end
        CMD_SEARCH: begin
          launch_nxt.op = OP_SEARCH;
        end
        default: begin
          // Unused command codes change nothing and answer ok.
          direct = 1'b1;
        end
      endcase

      if (direct) begin
        rsp_nxt.status         = direct_stat;
        rsp_nxt.data_out       = '0;
        rsp_nxt.found          = 1'b0;
        rsp_nxt.found_position = '0;
        rsp_nxt.list_length    = count_r;
        launch_nxt.valid       = 1'b0;
        state_nxt              = S_DONE;
      end else begin
        launch_nxt.valid = 1'b1;
        state_nxt        = S_BUSY;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      count_r        <= '0;
      launch_r.valid <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      launch_r <= launch_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    rsp_r <= rsp_nxt;
  end

  assign out_valid = (state_r == S_DONE);
  assign out_rsp   = rsp_r;
  assign launch    = launch_r;

endmodule

// ===== hw/rtl/indexed_linked_list_engine.sv =====
// Top level of the indexed linked list engine. Depends on ill_pkg,
// ill_ctrl and ill_chain.
//
// The engine keeps an ordered list of up to 128 signed 32-bit entries and
// answers one response per request: get, set, append, insert, remove or
// search. The list lives in a row of 128 cells, cell i holding position i.
// A request that passes its range and full checks launches a token that
// walks the row one cell per cycle and edits or reads the cells on its way,
// so its response comes only after the token has passed the launch register,
// every cell of the row and the response register, whatever the position or
// length. A request rejected with a range or full status, or an unused
// command code, is answered in the cycle after it is taken.
// One request is worked on at a time; the next one is taken in the cycle
// the waiting response is picked up. No pass is needed after reset.
module indexed_linked_list_engine
  import ill_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ill_in_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output ill_out_t out_rsp
);

  ill_tok_t launch;
  ill_tok_t chain_tok;

  // Request checks, response register and list length.
  ill_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .launch    (launch),
    .chain_tok (chain_tok)
  );

  // Cell row holding the list entries.
  ill_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .tok_in  (launch),
    .tok_out (chain_tok)
  );

endmodule
